FILE: src/pixel_replicating_upscaler_assert.svh
// Assertion macros for the pixel replicating upscaler checker.
// No dependencies; included by the checker file.
`ifndef PIXEL_REPLICATING_UPSCALER_ASSERT_SVH
`define PIXEL_REPLICATING_UPSCALER_ASSERT_SVH

// same-cycle implication
`define PRU_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("pru check failed");

// next-cycle implication
`define PRU_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("pru check failed");

`endif

FILE: src/pru_pkg.sv
// Package for the pixel replicating upscaler: widths, limits, codes.
// No dependencies; used by the result interface, the top level and the checker.
package pru_pkg;

    localparam int MAX_WIDTH  = 1024;
    localparam int MAX_FACTOR = 100;
    localparam int ADDR_W     = $clog2(MAX_WIDTH);
    localparam int CNT_W      = ADDR_W + 1;
    localparam int LW_W       = 11;
    localparam int SF_W       = 7;
    localparam int WCMP_W     = (LW_W > CNT_W) ? LW_W : CNT_W;
    localparam int PIX_W      = 24;
    localparam int APB_DW     = 32;
    localparam int PADDR_W    = 3;
    localparam int REG_SEL_BIT = 2;

    localparam logic CMD_PUSH = 1'b0;
    localparam logic CMD_PULL = 1'b1;

    localparam logic REG_LINE_WIDTH   = 1'b0;
    localparam logic REG_SCALE_FACTOR = 1'b1;

    typedef enum logic [2:0] {
        KIND_PIXEL        = 3'd0,
        KIND_PAD          = 3'd1,
        KIND_NOT_READY    = 3'd2,
        KIND_PUSH_OK      = 3'd3,
        KIND_PUSH_REFUSED = 3'd4
    } t_kind;

endpackage

FILE: src/pru_in_if.sv
// Input channel of the upscaler: push/pull command plus pixel bytes.
// No dependencies.
interface pru_in_if;
    logic       valid;
    logic       ready;
    logic       command;
    logic [7:0] red_in;
    logic [7:0] green_in;
    logic [7:0] blue_in;

    modport source (output valid, command, red_in, green_in, blue_in, input ready);
    modport sink   (input valid, command, red_in, green_in, blue_in, output ready);
endinterface

FILE: src/pru_out_if.sv
// Result channel of the upscaler: unit kind, pixel bytes, row markers.
// Depends on pru_pkg.
interface pru_out_if;
    import pru_pkg::*;
    logic       valid;
    logic       ready;
    t_kind      kind;
    logic [7:0] red_out;
    logic [7:0] green_out;
    logic [7:0] blue_out;
    logic       row_end;
    logic       line_done;

    modport source (output valid, kind, red_out, green_out, blue_out, row_end, line_done,
                    input ready);
    modport sink   (input valid, kind, red_out, green_out, blue_out, row_end, line_done,
                    output ready);
endinterface

FILE: src/pixel_replicating_upscaler.sv
// Nearest-neighbor integer upscaler with a single line store and APB config.
// Depends on pru_pkg, pru_in_if and pru_out_if.
//
//  channel  | dir | handshake      | payload
//  ---------+-----+----------------+------------------------------------------
//  i_pix    | in  | valid/ready    | command, red_in, green_in, blue_in
//  o_unit   | out | valid/ready    | kind, red/green/blue_out, row_end, line_done
//  apb      | in  | psel/penable   | paddr, pwdata -> prdata, pready=1
//
//  One transfer per clock while results are taken; every transfer gives one result in the next cycle.
//  Rate is set by the result handshake; the single-port line store read is registered with the result.
//  The result register frees i_pix.ready whenever it is empty or being taken.
//  Reset clears counters and the result valid; line_width and scale_factor go to 1.
//  The line store is not cleared; only entries of the current row are read.
module pixel_replicating_upscaler (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    pru_in_if.sink                      i_pix,
    pru_out_if.source                   o_unit,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [pru_pkg::PADDR_W-1:0] paddr,
    input  logic [pru_pkg::APB_DW-1:0]  pwdata,
    output logic [pru_pkg::APB_DW-1:0]  prdata,
    output logic                        pready
);
    import pru_pkg::*;

    logic [PIX_W-1:0]  r_line_store [MAX_WIDTH];
    logic [PIX_W-1:0]  r_rd_data;

    logic [LW_W-1:0]   r_line_width;
    logic [SF_W-1:0]   r_scale_factor;

    logic [CNT_W-1:0]  r_loaded_count, n_loaded_count;
    logic [ADDR_W-1:0] r_out_column, n_out_column;
    logic [SF_W-1:0]   r_replica_count, n_replica_count;
    logic [SF_W-1:0]   r_row_repeat, n_row_repeat;
    logic [1:0]        r_pad_left, n_pad_left;

    logic              r_out_valid;
    t_kind             r_kind, n_kind;
    logic              r_row_end, n_row_end;
    logic              r_line_done, n_line_done;

    logic              cfg_wr;
    logic              in_accept;
    logic              is_full;
    logic              do_push;
    logic              do_read;
    logic              row_close;
    logic [CNT_W-1:0]  eff_width;
    logic [SF_W-1:0]   eff_factor;
    logic [CNT_W-1:0]  col_inc;
    logic [SF_W-1:0]   rep_inc;
    logic [SF_W-1:0]   row_inc;
    logic [1:0]        row_pad;

    assign pready    = 1'b1;
    assign cfg_wr    = psel && penable && pwrite && pready;
    assign i_pix.ready = !r_out_valid || o_unit.ready;
    assign in_accept = i_pix.valid && i_pix.ready;

    always_comb begin
        if (r_line_width == '0) begin
            eff_width = CNT_W'(1);
        end else if (WCMP_W'(r_line_width) > WCMP_W'(MAX_WIDTH)) begin
            eff_width = CNT_W'(MAX_WIDTH);
        end else begin
            eff_width = CNT_W'(r_line_width);
        end
        if (r_scale_factor == '0) begin
            eff_factor = SF_W'(1);
        end else if (r_scale_factor > SF_W'(MAX_FACTOR)) begin
            eff_factor = SF_W'(MAX_FACTOR);
        end else begin
            eff_factor = r_scale_factor;
        end
    end

    assign is_full = r_loaded_count >= eff_width;
    assign col_inc = {1'b0, r_out_column} + CNT_W'(1);
    assign rep_inc = r_replica_count + SF_W'(1);
    assign row_inc = r_row_repeat + SF_W'(1);
    // (width * factor) mod 4 only needs the low two bits of each
    assign row_pad = 2'(eff_width[1:0] * eff_factor[1:0]);

    always_comb begin
        n_loaded_count  = r_loaded_count;
        n_out_column    = r_out_column;
        n_replica_count = r_replica_count;
        n_row_repeat    = r_row_repeat;
        n_pad_left      = r_pad_left;
        n_kind          = KIND_NOT_READY;
        n_row_end       = 1'b0;
        n_line_done     = 1'b0;
        do_push         = 1'b0;
        do_read         = 1'b0;
        row_close       = 1'b0;

        if (i_pix.command == CMD_PUSH) begin
            if (is_full) begin
                n_kind = KIND_PUSH_REFUSED;
            end else begin
                do_push        = 1'b1;
                n_loaded_count = r_loaded_count + CNT_W'(1);
                n_kind         = KIND_PUSH_OK;
            end
        end else if (!is_full) begin
            n_kind = KIND_NOT_READY;
        end else if (r_pad_left != 2'd0) begin
            n_kind     = KIND_PAD;
            n_pad_left = r_pad_left - 2'd1;
            if (r_pad_left == 2'd1) begin
                n_row_end = 1'b1;
                row_close = 1'b1;
            end
        end else begin
            n_kind  = KIND_PIXEL;
            do_read = 1'b1;
            if (rep_inc >= eff_factor) begin
                n_replica_count = '0;
                if (col_inc >= eff_width) begin
                    n_out_column = '0;
                    if (row_pad == 2'd0) begin
                        n_row_end = 1'b1;
                        row_close = 1'b1;
                    end else begin
                        n_pad_left = row_pad;
                    end
                end else begin
                    n_out_column = col_inc[ADDR_W-1:0];
                end
            end else begin
                n_replica_count = rep_inc;
            end
        end

        if (row_close) begin
            n_row_repeat = row_inc;
            if (row_inc >= eff_factor) begin
                n_line_done     = 1'b1;
                n_loaded_count  = '0;
                n_out_column    = '0;
                n_replica_count = '0;
                n_row_repeat    = '0;
                n_pad_left      = '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_line_width    <= LW_W'(1);
            r_scale_factor  <= SF_W'(1);
            r_loaded_count  <= '0;
            r_out_column    <= '0;
            r_replica_count <= '0;
            r_row_repeat    <= '0;
            r_pad_left      <= '0;
            r_out_valid     <= 1'b0;
        end else begin
            if (in_accept) begin
                r_loaded_count  <= n_loaded_count;
                r_out_column    <= n_out_column;
                r_replica_count <= n_replica_count;
                r_row_repeat    <= n_row_repeat;
                r_pad_left      <= n_pad_left;
            end
            if (cfg_wr) begin
                // any register write aborts the current row
                r_loaded_count  <= '0;
                r_out_column    <= '0;
                r_replica_count <= '0;
                r_row_repeat    <= '0;
                r_pad_left      <= '0;
                case (paddr[REG_SEL_BIT])
                    REG_LINE_WIDTH: begin
                        r_line_width <= pwdata[LW_W-1:0];
                    end
                    REG_SCALE_FACTOR: begin
                        r_scale_factor <= pwdata[SF_W-1:0];
                    end
                    default: begin
                    end
                endcase
            end
            if (in_accept) begin
                r_out_valid <= 1'b1;
            end else if (o_unit.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_kind      <= n_kind;
            r_row_end   <= n_row_end;
            r_line_done <= n_line_done;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept && do_push) begin
            r_line_store[r_loaded_count[ADDR_W-1:0]] <=
                {i_pix.red_in, i_pix.green_in, i_pix.blue_in};
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept && do_read) begin
            r_rd_data <= r_line_store[r_out_column];
        end
    end

    always_comb begin
        case (paddr[REG_SEL_BIT])
            REG_LINE_WIDTH:   prdata = APB_DW'(r_line_width);
            REG_SCALE_FACTOR: prdata = APB_DW'(r_scale_factor);
            default:          prdata = '0;
        endcase
    end

    assign o_unit.valid     = r_out_valid;
    assign o_unit.kind      = r_kind;
    assign o_unit.red_out   = (r_kind == KIND_PIXEL) ? r_rd_data[23:16] : 8'd0;
    assign o_unit.green_out = (r_kind == KIND_PIXEL) ? r_rd_data[15:8]  : 8'd0;
    assign o_unit.blue_out  = (r_kind == KIND_PIXEL) ? r_rd_data[7:0]   : 8'd0;
    assign o_unit.row_end   = r_row_end;
    assign o_unit.line_done = r_line_done;

endmodule

FILE: src/pru_checker.sv
// Port-level checker for the pixel replicating upscaler, bound to the top level.
// Depends on pru_pkg and pixel_replicating_upscaler_assert.svh.
`include "pixel_replicating_upscaler_assert.svh"

module pru_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_in_valid,
    input logic       i_in_ready,
    input logic       i_out_valid,
    input logic       i_out_ready,
    input logic [2:0] i_kind,
    input logic [7:0] i_red,
    input logic [7:0] i_green,
    input logic [7:0] i_blue,
    input logic       i_row_end,
    input logic       i_line_done
);
    import pru_pkg::*;

    `PRU_ASSERT_NEXT(a_stall_hold, i_clk, i_rst_n, i_out_valid && !i_out_ready, i_out_valid && $stable(i_kind) && $stable(i_red) && $stable(i_green) && $stable(i_blue) && $stable(i_row_end) && $stable(i_line_done))

    `PRU_ASSERT_NEXT(a_no_spurious_out, i_clk, i_rst_n, !(i_in_valid && i_in_ready) && !i_out_valid, !i_out_valid)

    `PRU_ASSERT_SAME(a_color_zero, i_clk, i_rst_n, i_out_valid && (i_kind != KIND_PIXEL), (i_red == 8'd0) && (i_green == 8'd0) && (i_blue == 8'd0))

    `PRU_ASSERT_SAME(a_done_ends_row, i_clk, i_rst_n, i_out_valid && i_line_done, i_row_end && ((i_kind == KIND_PIXEL) || (i_kind == KIND_PAD)))

endmodule

bind pixel_replicating_upscaler pru_checker u_pru_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_pix.valid),
    .i_in_ready  (i_pix.ready),
    .i_out_valid (o_unit.valid),
    .i_out_ready (o_unit.ready),
    .i_kind      (o_unit.kind),
    .i_red       (o_unit.red_out),
    .i_green     (o_unit.green_out),
    .i_blue      (o_unit.blue_out),
    .i_row_end   (o_unit.row_end),
    .i_line_done (o_unit.line_done)
);
